// ===== sv/polyline_turn_angle_error_unit_defines.svh =====
// Assertion macros shared by the polyline turn angle error unit.
`ifndef POLYLINE_TURN_ANGLE_ERROR_UNIT_DEFINES_SVH
`define POLYLINE_TURN_ANGLE_ERROR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTAE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PTAE_ASSERT_NORST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PTAE_ASSERT(label, prop, msg)
`define PTAE_ASSERT_NORST(label, prop, msg)
`endif
`endif

// ===== sv/ptae_pkg.sv =====
// Types, constants and the arctangent table of the polyline turn angle error unit.
package ptae_pkg;

   localparam int COORD_W     = 32;
   localparam int VEC_W       = 33;
   localparam int CORDIC_W    = 37;
   localparam int ANG_BITS    = 23;
   localparam int STEP_W      = 5;
   localparam int CORDIC_STEPS = 22;
   localparam int CNT_W       = 16;
   localparam int SUM_W       = 40;
   localparam int MEAN_W      = 24;
   localparam int DIVIDEND_W  = 41;
   localparam int DIV_CNT_W   = 6;
   localparam int M_W         = 25;
   localparam int RECIP_W     = 32;
   localparam int PROD_W      = M_W + RECIP_W;
   localparam int RECIP_SHIFT = 33;

   localparam logic [ANG_BITS-1:0] HALF_TURN  = 23'h40_0000;
   localparam logic [CNT_W-1:0]    MAX_POINTS = 16'hFFFF;
   localparam logic [RECIP_W-1:0]  RECIP3     = 32'hAAAA_AAAB;
   localparam logic signed [CORDIC_W-1:0] NORM_COARSE = 37'sd536870912;
   localparam logic signed [CORDIC_W-1:0] NORM_TARGET = 37'sd4294967296;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      is_last;
   } req_type;

   typedef struct packed {
      logic [MEAN_W-1:0] mean_error;
      logic              degenerate;
      logic [CNT_W-1:0]  point_count;
   } rsp_type;

   typedef struct packed {
      logic                    start;
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
   } cordic_req_type;

   typedef struct packed {
      logic                done;
      logic [ANG_BITS-1:0] angle;
   } cordic_rsp_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [CNT_W-1:0]      divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

   // atan(2^-i) with a half turn equal to 2^22
   function automatic logic [ANG_BITS-1:0] atan_lookup(input logic [STEP_W-1:0] idx);
      logic [ANG_BITS-1:0] val;
      case (idx)
         5'd0:    val = 23'd1048576;
         5'd1:    val = 23'd619011;
         5'd2:    val = 23'd327068;
         5'd3:    val = 23'd166025;
         5'd4:    val = 23'd83335;
         5'd5:    val = 23'd41708;
         5'd6:    val = 23'd20859;
         5'd7:    val = 23'd10430;
         5'd8:    val = 23'd5215;
         5'd9:    val = 23'd2608;
         5'd10:   val = 23'd1304;
         5'd11:   val = 23'd652;
         5'd12:   val = 23'd326;
         5'd13:   val = 23'd163;
         5'd14:   val = 23'd81;
         5'd15:   val = 23'd41;
         5'd16:   val = 23'd20;
         5'd17:   val = 23'd10;
         5'd18:   val = 23'd5;
         5'd19:   val = 23'd3;
         5'd20:   val = 23'd1;
         5'd21:   val = 23'd1;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ===== sv/ptae_cordic.sv =====
// Iterative CORDIC vectoring unit: normalizes a vector, then one rotation step per cycle.
module ptae_cordic
   import ptae_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  cordic_req_type req,
   output cordic_rsp_type rsp
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_NORM = 2'd1;
   localparam logic [1:0] ST_ITER = 2'd2;

   logic [1:0]                 state_ff, state_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [ANG_BITS-1:0]        z_ff, z_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       done_ff, done_in;

   logic signed [CORDIC_W-1:0] x_ext, y_ext, y_abs, mag, xs, ys;
   logic                       y_pos;

   always_comb begin
      x_ext = {{(CORDIC_W-VEC_W){req.x[VEC_W-1]}}, req.x};
      y_ext = {{(CORDIC_W-VEC_W){req.y[VEC_W-1]}}, req.y};
      y_abs = y_ff[CORDIC_W-1] ? -y_ff : y_ff;
      mag   = (x_ff > y_abs) ? x_ff : y_abs;
      xs    = x_ff >>> step_ff;
      ys    = y_ff >>> step_ff;
      y_pos = !y_ff[CORDIC_W-1] && (y_ff != '0);

      state_in = state_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      step_in  = step_ff;
      done_in  = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req.start) begin
               // fold the left half plane onto the right one
               if (x_ext[CORDIC_W-1]) begin
                  x_in = -x_ext;
                  y_in = -y_ext;
                  z_in = HALF_TURN;
               end else begin
                  x_in = x_ext;
                  y_in = y_ext;
                  z_in = '0;
               end
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (mag < NORM_COARSE) begin
               x_in = x_ff <<< 4;
               y_in = y_ff <<< 4;
            end else if (mag < NORM_TARGET) begin
               x_in = x_ff <<< 1;
               y_in = y_ff <<< 1;
            end else begin
               step_in  = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            if (y_pos) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_lookup(step_ff);
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_lookup(step_ff);
            end
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.angle = z_ff;

endmodule

// ===== sv/ptae_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module ptae_divider
   import ptae_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  count_ff, count_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [CNT_W-1:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]      divisor_ff, divisor_in;

   logic [CNT_W:0] rem_wide, diff;
   logic           fits;

   always_comb begin
      rem_wide = {rem_ff, quot_ff[DIVIDEND_W-1]};
      diff     = rem_wide - {1'b0, divisor_ff};
      fits     = rem_wide >= {1'b0, divisor_ff};

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;

      if (!busy_ff) begin
         if (req.start) begin
            busy_in    = 1'b1;
            count_in   = DIV_CNT_W'(DIVIDEND_W);
            quot_in    = req.dividend;
            rem_in     = '0;
            divisor_in = req.divisor;
         end
      end else begin
         rem_in   = fits ? diff[CNT_W-1:0] : rem_wide[CNT_W-1:0];
         quot_in  = {quot_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff   <= count_in;
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quot_ff;

endmodule

// ===== sv/polyline_turn_angle_error_unit.sv =====
// Polyline turn angle error unit: mean turn error of a 2D polyline, one point per request.
//
// Requests carry one point (x, y in signed Q15.16) and a last-point flag. A request
// is taken at a rising edge with start high and busy low; busy stays high until the
// point is fully processed. On the last point one result (mean error in Q2.22, a
// sticky zero-length-segment flag and the saturated point count) is shown on rsp_data
// for exactly one cycle, marked by rsp_strobe; the receiver cannot hold it off.
// The first two points of a polyline go straight from the check to the history update.
// Each later point runs the shared CORDIC vectoring unit twice, once per segment;
// each run does 1 to 10 normalizing shifts, a range check and 22 rotation steps.
// A point with a zero-length segment skips both runs.
// The last point adds the bit-serial mean division (41 quotient bits) when the
// polyline has three or more points; otherwise the mean is zero.
// Synchronous reset clears the point history, count, sum and flag and aborts any
// point in flight; after a result these are cleared for the next polyline.
`include "polyline_turn_angle_error_unit_defines.svh"
module polyline_turn_angle_error_unit
   import ptae_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_CHECK   = 4'd1;
   localparam logic [3:0] ST_WAIT1   = 4'd2;
   localparam logic [3:0] ST_START0  = 4'd3;
   localparam logic [3:0] ST_WAIT0   = 4'd4;
   localparam logic [3:0] ST_THETA   = 4'd5;
   localparam logic [3:0] ST_MUL     = 4'd6;
   localparam logic [3:0] ST_ACC     = 4'd7;
   localparam logic [3:0] ST_UPDATE  = 4'd8;
   localparam logic [3:0] ST_DIVGO   = 4'd9;
   localparam logic [3:0] ST_DIVWAIT = 4'd10;
   localparam logic [3:0] ST_OUT     = 4'd11;

   logic [3:0]                state_ff, state_in;
   req_type                   point_ff, point_in;
   logic signed [COORD_W-1:0] hist_x_ff [2];
   logic signed [COORD_W-1:0] hist_x_in [2];
   logic signed [COORD_W-1:0] hist_y_ff [2];
   logic signed [COORD_W-1:0] hist_y_in [2];
   logic [CNT_W-1:0]          points_ff, points_in;
   logic [SUM_W-1:0]          sum_ff, sum_in;
   logic                      degen_ff, degen_in;
   logic [ANG_BITS-1:0]       ang1_ff, ang1_in, ang0_ff, ang0_in;
   logic [M_W-1:0]            m_ff, m_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [MEAN_W-1:0]         mean_ff, mean_in;

   logic signed [VEC_W-1:0] d0x, d0y, d1x, d1y;
   logic                    d0_zero, d1_zero, last_ff;
   logic [ANG_BITS-1:0]     dth, th, ang_left;
   logic [MEAN_W-1:0]       term;
   logic [SUM_W:0]          sum_wide;

   cordic_req_type cordic_req;
   cordic_rsp_type cordic_rsp;
   div_req_type    div_req;
   div_rsp_type    div_rsp;

   ptae_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .req   (cordic_req),
      .rsp   (cordic_rsp)
   );

   ptae_divider u_divider (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign last_ff = point_ff.is_last;

   always_comb begin
      d1x = VEC_W'(point_ff.point_x) - VEC_W'(hist_x_ff[1]);
      d1y = VEC_W'(point_ff.point_y) - VEC_W'(hist_y_ff[1]);
      d0x = VEC_W'(hist_x_ff[0]) - VEC_W'(hist_x_ff[1]);
      d0y = VEC_W'(hist_y_ff[0]) - VEC_W'(hist_y_ff[1]);
      d0_zero = (d0x == '0) && (d0y == '0);
      d1_zero = (d1x == '0) && (d1y == '0);

      // fold the turn into [0, half turn]
      dth      = ang1_ff - ang0_ff;
      th       = (dth > HALF_TURN) ? -dth : dth;
      ang_left = HALF_TURN - th;
      term     = prod_ff[RECIP_SHIFT +: MEAN_W];
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(term);
   end

   always_comb begin
      cordic_req.start = ((state_ff == ST_CHECK) && (points_ff >= CNT_W'(2))
                          && !d0_zero && !d1_zero) || (state_ff == ST_START0);
      cordic_req.x     = (state_ff == ST_START0) ? d0x : d1x;
      cordic_req.y     = (state_ff == ST_START0) ? d0y : d1y;

      div_req.start    = (state_ff == ST_DIVGO) && (points_ff >= CNT_W'(3));
      div_req.dividend = DIVIDEND_W'(sum_ff) + DIVIDEND_W'(points_ff >> 1);
      div_req.divisor  = points_ff;
   end

   always_comb begin
      state_in  = state_ff;
      point_in  = point_ff;
      hist_x_in = hist_x_ff;
      hist_y_in = hist_y_ff;
      points_in = points_ff;
      sum_in    = sum_ff;
      degen_in  = degen_ff;
      ang1_in   = ang1_ff;
      ang0_in   = ang0_ff;
      m_in      = m_ff;
      prod_in   = prod_ff;
      mean_in   = mean_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               point_in = req_data;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (points_ff < CNT_W'(2)) begin
               state_in = ST_UPDATE;
            end else if (d0_zero || d1_zero) begin
               degen_in = 1'b1;
               state_in = ST_UPDATE;
            end else begin
               state_in = ST_WAIT1;
            end
         end
         ST_WAIT1: begin
            if (cordic_rsp.done) begin
               ang1_in  = cordic_rsp.angle;
               state_in = ST_START0;
            end
         end
         ST_START0: begin
            state_in = ST_WAIT0;
         end
         ST_WAIT0: begin
            if (cordic_rsp.done) begin
               ang0_in  = cordic_rsp.angle;
               state_in = ST_THETA;
            end
         end
         ST_THETA: begin
            // (8a + 3) / 6 equals (4a + 1) / 3
            m_in     = M_W'({ang_left, 2'b00}) + M_W'(1);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = PROD_W'(m_ff) * PROD_W'(RECIP3);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            hist_x_in[0] = hist_x_ff[1];
            hist_y_in[0] = hist_y_ff[1];
            hist_x_in[1] = point_ff.point_x;
            hist_y_in[1] = point_ff.point_y;
            if (points_ff != MAX_POINTS) begin
               points_in = points_ff + CNT_W'(1);
            end
            state_in = last_ff ? ST_DIVGO : ST_IDLE;
         end
         ST_DIVGO: begin
            if (points_ff >= CNT_W'(3)) begin
               state_in = ST_DIVWAIT;
            end else begin
               mean_in  = '0;
               state_in = ST_OUT;
            end
         end
         ST_DIVWAIT: begin
            if (div_rsp.done) begin
               mean_in = (div_rsp.quotient[DIVIDEND_W-1:MEAN_W] != '0) ? '1
                         : div_rsp.quotient[MEAN_W-1:0];
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // drop the polyline once its result is out
            hist_x_in[0] = '0;
            hist_x_in[1] = '0;
            hist_y_in[0] = '0;
            hist_y_in[1] = '0;
            points_in    = '0;
            sum_in       = '0;
            degen_in     = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hist_x_ff[0] <= '0;
         hist_x_ff[1] <= '0;
         hist_y_ff[0] <= '0;
         hist_y_ff[1] <= '0;
         points_ff    <= '0;
         sum_ff       <= '0;
         degen_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         hist_x_ff <= hist_x_in;
         hist_y_ff <= hist_y_in;
         points_ff <= points_in;
         sum_ff    <= sum_in;
         degen_ff  <= degen_in;
      end
   end

   always_ff @(posedge clock) begin
      point_ff <= point_in;
      ang1_ff  <= ang1_in;
      ang0_ff  <= ang0_in;
      m_ff     <= m_in;
      prod_ff  <= prod_in;
      mean_ff  <= mean_in;
   end

   assign busy                 = (state_ff != ST_IDLE);
   assign rsp_strobe           = (state_ff == ST_OUT);
   assign rsp_data.mean_error  = mean_ff;
   assign rsp_data.degenerate  = degen_ff;
   assign rsp_data.point_count = points_ff;

   `PTAE_ASSERT_NORST(a_reset_idle, reset |=> !busy && !rsp_strobe, "block not idle after reset")
   `PTAE_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted request did not raise busy")
   `PTAE_ASSERT(a_strobe_pulse, rsp_strobe |=> !rsp_strobe, "result strobe longer than one cycle")
   `PTAE_ASSERT(a_result_last, rsp_strobe |-> last_ff && (rsp_data.point_count >= CNT_W'(3) || rsp_data.mean_error == '0), "result without last point or nonzero mean on short polyline")
   `PTAE_ASSERT(a_cordic_expected, cordic_rsp.done |-> (state_ff == ST_WAIT1 || state_ff == ST_WAIT0), "angle finished while sequencer not waiting")

endmodule
